// ===== rtl/scan_beam_block_parser_unit_defines.svh =====
// Assertion macros for the scan beam block parser.
// Used by the RTL modules; no other dependencies.
`ifndef SCAN_BEAM_BLOCK_PARSER_UNIT_DEFINES_SVH
`define SCAN_BEAM_BLOCK_PARSER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define SBBP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define SBBP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define SBBP_ASSERT(lbl, prop, msg)
`define SBBP_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/sbbp_pkg.sv =====
// Package for the scan beam block parser: types, codes and defaults.
// No dependencies.
`default_nettype none
package sbbp_pkg;

   localparam int DEFAULT_BEAM_INDEX_WIDTH = 12;
   localparam int DEFAULT_ANGLE_WIDTH = 32;
   localparam logic [11:0] DEFAULT_BEAM_LIMIT = 12'd2751;
   localparam int QUEUE_DEPTH = 4;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic [7:0] STATUS_VALID_MASK = 8'h01;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_ANGLE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ANGLE_STEP = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BEAM_LIMIT = 2'd2;

   typedef enum logic [1:0] {
      KIND_POINT = 2'd0,
      KIND_EMPTY = 2'd1,
      KIND_REJECT = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CMD_START,
      CMD_POINT,
      CMD_EMPTY,
      CMD_REJECT
   } cmd_op_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_COUNT1 = 3'd1,
      PH_COUNT2 = 3'd2,
      PH_COUNT3 = 3'd3,
      PH_RECORDS = 3'd4
   } phase_type;

   typedef struct packed {
      cmd_op_type op;
      logic [15:0] distance;
      logic [7:0] reflectivity;
      logic [5:0] status;
      logic last;
   } cmd_type;

   typedef struct packed {
      logic push;
      cmd_type cmd;
   } push_type;

   typedef struct packed {
      logic signed [31:0] start_angle;
      logic signed [31:0] angle_step;
      logic [11:0] beam_limit;
   } cfg_type;

endpackage
`default_nettype wire

// ===== rtl/sbbp_channels.sv =====
// Channel interfaces for the byte input and the result output.
// Plain valid/ready handshake; no package dependencies.
`default_nettype none
interface sbbp_req_if;
   logic valid;
   logic ready;
   logic [7:0] data_byte;
   logic block_start;
   modport source (output valid, output data_byte, output block_start, input ready);
   modport sink (input valid, input data_byte, input block_start, output ready);
endinterface

interface sbbp_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] kind;
   logic signed [31:0] beam_angle;
   logic [15:0] distance;
   logic [7:0] reflectivity;
   logic valid_flag;
   logic infinite_flag;
   logic glare_flag;
   logic reflector_flag;
   logic contamination_flag;
   logic contamination_warn;
   logic last;
   modport source (output valid, output kind, output beam_angle, output distance,
                   output reflectivity, output valid_flag, output infinite_flag,
                   output glare_flag, output reflector_flag, output contamination_flag,
                   output contamination_warn, output last, input ready);
   modport sink (input valid, input kind, input beam_angle, input distance,
                 input reflectivity, input valid_flag, input infinite_flag,
                 input glare_flag, input reflector_flag, input contamination_flag,
                 input contamination_warn, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/sbbp_front.sv =====
// Front end: accepts bytes, tracks the block header and beam records, and
// pushes commands into the queue. Depends on sbbp_pkg and sbbp_req_if.
`default_nettype none
`include "scan_beam_block_parser_unit_defines.svh"
module sbbp_front
   import sbbp_pkg::*;
#(
   parameter int BEAM_INDEX_WIDTH = DEFAULT_BEAM_INDEX_WIDTH
) (
   input wire logic clock,
   input wire logic reset,
   sbbp_req_if.sink req_ch,
   input wire logic queue_full,
   input wire logic [11:0] beam_limit,
   output push_type push_out
);

   phase_type phase_ff, phase_in;
   logic [31:0] count_ff, count_in;
   logic [BEAM_INDEX_WIDTH-1:0] done_ff, done_in;
   logic [1:0] rec_ff, rec_in;
   logic [15:0] dist_ff, dist_in;
   logic [7:0] refl_ff, refl_in;

   logic accept;
   logic [7:0] b;
   logic [31:0] full_count;
   logic [BEAM_INDEX_WIDTH-1:0] done_next;
   logic over_limit;
   logic zero_count;
   logic final_beam;

   assign req_ch.ready = !queue_full;
   assign accept = req_ch.valid && req_ch.ready;
   assign b = req_ch.data_byte;
   assign full_count = {b, count_ff[23:0]};
   assign over_limit = full_count > {20'd0, beam_limit};
   assign zero_count = full_count == 32'd0;
   assign done_next = done_ff + 1'b1;
   assign final_beam = 32'(done_next) == count_ff;

   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         if (req_ch.block_start) begin
            phase_in = PH_COUNT1;
         end else begin
            unique case (phase_ff)
               PH_IDLE: phase_in = PH_IDLE;
               PH_COUNT1: phase_in = PH_COUNT2;
               PH_COUNT2: phase_in = PH_COUNT3;
               PH_COUNT3: phase_in = (over_limit || zero_count) ? PH_IDLE : PH_RECORDS;
               PH_RECORDS: phase_in = (rec_ff == 2'd3 && final_beam) ? PH_IDLE : PH_RECORDS;
               default: phase_in = PH_IDLE;
            endcase
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      done_in = done_ff;
      rec_in = rec_ff;
      dist_in = dist_ff;
      refl_in = refl_ff;
      push_out = '0;
      push_out.cmd.op = CMD_START;
      push_out.cmd.distance = dist_ff;
      push_out.cmd.reflectivity = refl_ff;
      push_out.cmd.status = b[5:0];
      if (accept) begin
         if (req_ch.block_start) begin
            count_in = {24'd0, b};
            done_in = '0;
            rec_in = '0;
            push_out.push = 1'b1;
            push_out.cmd.op = CMD_START;
         end else begin
            unique case (phase_ff)
               PH_COUNT1: count_in[15:8] = b;
               PH_COUNT2: count_in[23:16] = b;
               PH_COUNT3: begin
                  count_in = full_count;
                  rec_in = '0;
                  if (over_limit) begin
                     push_out.push = 1'b1;
                     push_out.cmd.op = CMD_REJECT;
                     push_out.cmd.last = 1'b1;
                  end else if (zero_count) begin
                     push_out.push = 1'b1;
                     push_out.cmd.op = CMD_EMPTY;
                     push_out.cmd.last = 1'b1;
                  end
               end
               PH_RECORDS: begin
                  case (rec_ff)
                     2'd0: begin
                        dist_in = {8'd0, b};
                        rec_in = 2'd1;
                     end
                     2'd1: begin
                        dist_in[15:8] = b;
                        rec_in = 2'd2;
                     end
                     2'd2: begin
                        refl_in = b;
                        rec_in = 2'd3;
                     end
                     default: begin
                        done_in = done_next;
                        rec_in = '0;
                        push_out.push = 1'b1;
                        push_out.cmd.op = CMD_POINT;
                        push_out.cmd.last = final_beam;
                     end
                  endcase
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         done_ff <= '0;
         rec_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         done_ff <= done_in;
         rec_ff <= rec_in;
      end
      dist_ff <= dist_in;
      refl_ff <= refl_in;
   end

   `SBBP_ASSERT(a_rec_only_in_records, rec_ff != 2'd0 |-> phase_ff == PH_RECORDS,
                "Record byte counter moved outside the record phase.")
   `SBBP_ASSERT(a_start_pushes, accept && req_ch.block_start |-> push_out.push &&
                push_out.cmd.op == CMD_START, "Block start did not queue a start command.")
   `SBBP_ASSERT(a_push_needs_accept, push_out.push |-> accept,
                "Command queued without an accepted transaction.")

endmodule
`default_nettype wire

// ===== rtl/sbbp_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on sbbp_pkg.
`default_nettype none
`include "scan_beam_block_parser_unit_defines.svh"
module sbbp_queue
   import sbbp_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire push_type push_in,
   input wire logic pop,
   output logic full,
   output logic empty,
   output cmd_type head
);

   localparam int PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   cmd_type mem_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0] wr_ff, wr_in;
   logic [PTR_WIDTH-1:0] rd_ff, rd_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic do_push;
   logic do_pop;

   assign full = count_ff == COUNT_WIDTH'(QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign head = mem_ff[rd_ff];
   assign do_push = push_in.push && !full;
   assign do_pop = pop && !empty;

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_in.cmd;
      end
   end

   `SBBP_ASSERT(a_no_push_when_full, full |-> !push_in.push,
                "Command pushed into a full queue.")
   `SBBP_ASSERT(a_count_tracks, do_push && !do_pop |=> count_ff == $past(count_ff) + 1'b1,
                "Queue count did not follow a push.")
   `SBBP_ASSERT_ALWAYS(a_count_bound, count_ff <= COUNT_WIDTH'(QUEUE_DEPTH),
                       "Queue count exceeds its depth.")

endmodule
`default_nettype wire

// ===== rtl/sbbp_back.sv =====
// Back end: keeps the beam angle, turns commands into results and holds
// them in the output register. Depends on sbbp_pkg and sbbp_rsp_if.
`default_nettype none
`include "scan_beam_block_parser_unit_defines.svh"
module sbbp_back
   import sbbp_pkg::*;
#(
   parameter int ANGLE_WIDTH = DEFAULT_ANGLE_WIDTH
) (
   input wire logic clock,
   input wire logic reset,
   input wire cmd_type head,
   input wire logic queue_empty,
   input wire logic signed [31:0] start_angle,
   input wire logic signed [31:0] angle_step,
   output logic pop,
   sbbp_rsp_if.source rsp_ch
);

   logic [ANGLE_WIDTH-1:0] angle_ff, angle_in;
   logic out_valid_ff, out_valid_in;
   kind_type kind_ff, kind_in;
   logic [31:0] beam_angle_ff, beam_angle_in;
   logic [15:0] dist_ff, dist_in;
   logic [7:0] refl_ff, refl_in;
   logic [5:0] status_ff, status_in;
   logic last_ff, last_in;

   logic load_ok;
   logic emits;
   logic [ANGLE_WIDTH+31:0] start_wide;
   logic [ANGLE_WIDTH+31:0] step_wide;
   logic [ANGLE_WIDTH+31:0] angle_out_wide;

   assign start_wide = {{ANGLE_WIDTH{start_angle[31]}}, start_angle};
   assign step_wide = {{ANGLE_WIDTH{angle_step[31]}}, angle_step};
   assign angle_out_wide = {32'd0, angle_ff};

   assign load_ok = !out_valid_ff || rsp_ch.ready;
   assign emits = head.op != CMD_START;
   assign pop = !queue_empty && (!emits || load_ok);

   always_comb begin
      angle_in = angle_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      kind_in = kind_ff;
      beam_angle_in = beam_angle_ff;
      dist_in = dist_ff;
      refl_in = refl_ff;
      status_in = status_ff;
      last_in = last_ff;
      if (pop) begin
         unique case (head.op)
            CMD_START: angle_in = start_wide[ANGLE_WIDTH-1:0];
            CMD_POINT: begin
               angle_in = angle_ff + step_wide[ANGLE_WIDTH-1:0];
               out_valid_in = 1'b1;
               kind_in = KIND_POINT;
               beam_angle_in = angle_out_wide[31:0];
               dist_in = head.distance;
               refl_in = head.reflectivity;
               status_in = head.status;
               last_in = head.last;
            end
            default: begin
               out_valid_in = 1'b1;
               kind_in = (head.op == CMD_REJECT) ? KIND_REJECT : KIND_EMPTY;
               beam_angle_in = '0;
               dist_in = '0;
               refl_in = '0;
               status_in = '0;
               last_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         angle_ff <= angle_in;
         out_valid_ff <= out_valid_in;
      end
      kind_ff <= kind_in;
      beam_angle_ff <= beam_angle_in;
      dist_ff <= dist_in;
      refl_ff <= refl_in;
      status_ff <= status_in;
      last_ff <= last_in;
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.kind = kind_ff;
   assign rsp_ch.beam_angle = beam_angle_ff;
   assign rsp_ch.distance = dist_ff;
   assign rsp_ch.reflectivity = refl_ff;
   assign rsp_ch.valid_flag = status_ff[0];
   assign rsp_ch.infinite_flag = status_ff[1];
   assign rsp_ch.glare_flag = status_ff[2];
   assign rsp_ch.reflector_flag = status_ff[3];
   assign rsp_ch.contamination_flag = status_ff[4];
   assign rsp_ch.contamination_warn = status_ff[5];
   assign rsp_ch.last = last_ff;

   `SBBP_ASSERT(a_summary_is_last, out_valid_ff && kind_ff != KIND_POINT |-> last_ff,
                "Empty or rejected block result without the last mark.")
   `SBBP_ASSERT(a_no_overwrite, out_valid_ff && !rsp_ch.ready |-> !(pop && emits),
                "Result register overwritten while a transaction was pending.")
   `SBBP_ASSERT(a_pop_needs_entry, pop |-> !queue_empty,
                "Command taken from an empty queue.")

endmodule
`default_nettype wire

// ===== rtl/scan_beam_block_parser_unit.sv =====
// Top level of the scan beam block parser: configuration registers, front
// end, command queue and back end. Depends on sbbp_pkg and the channel files.
//
//   Channel   Direction  Handshake        Payload
//   req_ch    in         valid / ready    data_byte, block_start
//   rsp_ch    out        valid / ready    kind, beam_angle, distance, reflectivity, flags, last
//   csr_*     in         csr_we           csr_index, csr_wdata
//
// One byte is taken per cycle while the queue has room; the command for a result is
// queued when its last byte is taken and then loaded into the output register.
// The rate is set by the four-entry command queue: bytes are taken while it has room.
// A stalled result channel fills the queue, after which req_ch.ready drops.
// Reset is synchronous; it empties the queue and the output register.
`default_nettype none
module scan_beam_block_parser_unit
   import sbbp_pkg::*;
#(
   parameter int BEAM_INDEX_WIDTH = DEFAULT_BEAM_INDEX_WIDTH,
   parameter int ANGLE_WIDTH = DEFAULT_ANGLE_WIDTH
) (
   input wire logic clock,
   input wire logic reset,
   sbbp_req_if.sink req_ch,
   sbbp_rsp_if.source rsp_ch,
   input wire logic csr_we,
   input wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input wire logic [CSR_DATA_WIDTH-1:0] csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   push_type push;
   cmd_type head;
   logic queue_full;
   logic queue_empty;
   logic pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_START_ANGLE: cfg_in.start_angle = csr_wdata;
            CSR_ANGLE_STEP: cfg_in.angle_step = csr_wdata;
            CSR_BEAM_LIMIT: cfg_in.beam_limit = csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_angle <= '0;
         cfg_ff.angle_step <= '0;
         cfg_ff.beam_limit <= DEFAULT_BEAM_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sbbp_front #(
      .BEAM_INDEX_WIDTH(BEAM_INDEX_WIDTH)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .queue_full(queue_full),
      .beam_limit(cfg_ff.beam_limit),
      .push_out(push)
   );

   sbbp_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push_in(push),
      .pop(pop),
      .full(queue_full),
      .empty(queue_empty),
      .head(head)
   );

   sbbp_back #(
      .ANGLE_WIDTH(ANGLE_WIDTH)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .head(head),
      .queue_empty(queue_empty),
      .start_angle(cfg_ff.start_angle),
      .angle_step(cfg_ff.angle_step),
      .pop(pop),
      .rsp_ch(rsp_ch)
   );

endmodule
`default_nettype wire
